[src/bda_pkg.sv]
// shared types and constants for the button debounce with auto-repeat block
package bda_pkg;

  localparam int PIN_W  = 5;
  localparam int TIME_W = 32;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 2;

  localparam int NUM_BUTTONS_DEF = 5;

  // register indexes
  localparam logic [IDX_W-1:0] REG_IGNORE_INTERVAL = 2'd0;
  localparam logic [IDX_W-1:0] REG_REPEAT_START    = 2'd1;
  localparam logic [IDX_W-1:0] REG_REPEAT_PERIOD   = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0] IGNORE_INTERVAL_RST = 16'd20;
  localparam logic [CFG_W-1:0] REPEAT_START_RST    = 16'd500;
  localparam logic [CFG_W-1:0] REPEAT_PERIOD_RST   = 16'd100;

  typedef struct packed {
    logic [PIN_W-1:0]  pin_levels;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [PIN_W-1:0] changed_mask;
    logic [PIN_W-1:0] stable_mask;
    logic [PIN_W-1:0] repeating_mask;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] ignore_interval_ms;
    logic [CFG_W-1:0] repeat_start_ms;
    logic [CFG_W-1:0] repeat_period_ms;
  } cfg_t;

  typedef struct packed {
    logic evt;
    logic stable;
    logic active;
  } cell_out_t;

endpackage

[src/bda_cell.sv]
// per-button debounce and auto-repeat state with its update logic
module bda_cell
  import bda_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              upd,
  input  logic              raw,
  input  logic [TIME_W-1:0] now,
  input  cfg_t              cfg,
  output cell_out_t         res
);

  logic              stable_r, stable_nxt;
  logic              active_r, active_nxt;
  logic [TIME_W-1:0] quiet_r, quiet_nxt;
  logic [TIME_W-1:0] rep_r, rep_nxt;

  logic              ignore;
  logic              chg;
  logic              fire;
  logic [TIME_W-1:0] since_quiet;
  logic [TIME_W-1:0] held;
  logic [TIME_W-1:0] ign_ext;
  logic [TIME_W-1:0] limit;

  assign ign_ext     = {{(TIME_W-CFG_W){1'b0}}, cfg.ignore_interval_ms};
  assign since_quiet = now - quiet_r;
  assign ignore      = since_quiet < ign_ext;
  assign held        = now - rep_r;
  assign limit       = active_r ? {{(TIME_W-CFG_W){1'b0}}, cfg.repeat_period_ms}
                                : {{(TIME_W-CFG_W){1'b0}}, cfg.repeat_start_ms};

  always_comb begin
    stable_nxt = stable_r;
    active_nxt = active_r;
    quiet_nxt  = quiet_r;
    rep_nxt    = rep_r;
    chg        = 1'b0;
    fire       = 1'b0;
    if (!ignore) begin
      chg        = stable_r ^ raw;
      stable_nxt = raw;
      if (chg) begin
        quiet_nxt = now;
        if (raw) begin
          active_nxt = 1'b0;
        end else begin
          rep_nxt = now;
        end
      end else begin
        // keep the window just closed
        quiet_nxt = now - ign_ext;
        if (!raw && (held >= limit)) begin
          fire       = 1'b1;
          active_nxt = 1'b1;
          rep_nxt    = now;
        end
      end
    end
  end

  assign res.evt    = chg | fire;
  assign res.stable = stable_nxt;
  assign res.active = active_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= 1'b1;
      active_r <= 1'b0;
      quiet_r  <= '0;
      rep_r    <= '0;
    end else if (upd) begin
      stable_r <= stable_nxt;
      active_r <= active_nxt;
      quiet_r  <= quiet_nxt;
      rep_r    <= rep_nxt;
    end
  end

endmodule

[src/button_debounce_autorepeat_top.sv]
// top level of the button debounce with auto-repeat block
//
// usage:
//   in channel  : one transaction per scan, carrying the raw active-low button
//                 levels and the free-running millisecond time
//   out channel : one transaction per scan with the change mask, the debounced
//                 levels and the repeat flags
//   cfg channel : register writes (ignore interval, repeat start, repeat
//                 period); cfg_ready is always high, writes are expected only
//                 while the block is idle
// datapath: a scan is captured in the input register, evaluated by the
//   per-button cells and then lands in the output register, from which its
//   result shows on out_valid
// throughput: one scan per cycle while out_stall is low; each button needs
//   only a couple of 32-bit subtract-compare paths, and the button state
//   updates in the same cycle the scan moves to the output register
// reset: synchronous, active low; all buttons read released, timestamps go to
//   zero, repeat flags clear, registers take their default values
// stall: a held result keeps its payload; the input register still takes one
//   more scan, and in_stall rises only once both stages are full
module button_debounce_autorepeat_top
  import bda_pkg::*;
#(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  // scan input
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  // result output
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  // register writes
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  // configuration registers
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ignore_interval_ms <= IGNORE_INTERVAL_RST;
      cfg_r.repeat_start_ms    <= REPEAT_START_RST;
      cfg_r.repeat_period_ms   <= REPEAT_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IGNORE_INTERVAL: cfg_r.ignore_interval_ms <= cfg_data;
        REG_REPEAT_START:    cfg_r.repeat_start_ms    <= cfg_data;
        REG_REPEAT_PERIOD:   cfg_r.repeat_period_ms   <= cfg_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // input register and output register handshake
  logic      in_vld_r;
  in_item_t  in_r;
  logic      out_vld_r;
  out_item_t out_r, out_nxt;
  logic      in_take;
  logic      adv;

  // scan moves forward when the output register is empty or being drained
  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_data;
    end
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  // per-button cells; buttons past the pin field see a pressed level
  logic [NUM_BUTTONS-1:0] evt_v, stable_v, active_v;

  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
    logic      raw;
    cell_out_t res;

    if (b < PIN_W) begin : g_pin
      assign raw = in_r.pin_levels[b];
    end else begin : g_nopin
      assign raw = 1'b0;
    end

    bda_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .upd   (adv),
      .raw   (raw),
      .now   (in_r.now_ms),
      .cfg   (cfg_r),
      .res   (res)
    );

    assign evt_v[b]    = res.evt;
    assign stable_v[b] = res.stable;
    assign active_v[b] = res.active;
  end

  // result fields; bits without a button read released and idle
  for (genvar k = 0; k < PIN_W; k++) begin : g_out
    if (k < NUM_BUTTONS) begin : g_used
      assign out_nxt.changed_mask[k]   = evt_v[k];
      assign out_nxt.stable_mask[k]    = stable_v[k];
      assign out_nxt.repeating_mask[k] = active_v[k];
    end else begin : g_unused
      assign out_nxt.changed_mask[k]   = 1'b0;
      assign out_nxt.stable_mask[k]    = 1'b1;
      assign out_nxt.repeating_mask[k] = 1'b0;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

[src/bda_checker.sv]
// port-level assertions for the button debounce block and their bind
module bda_checker
  import bda_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // a repeating button is always a pressed button
  a_repeat_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.repeating_mask & out_data.stable_mask) == '0))
    else $error("repeat flag set on a released button");

  // no backpressure on the input while the output drains
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

  // reset empties the output register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind button_debounce_autorepeat_top bda_checker u_bda_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
